// ===== design/kai_pkg.sv =====
// Shared types, constants and helpers for the keyframe alpha interpolator.
// No dependencies; every other design file imports this package.
package kai_pkg;

   // Keyframe table
   localparam int KEYS      = 8;
   localparam int KEY_IDX_W = 3;
   localparam int KEY_REGS  = KEYS / 2;
   localparam int SEG_W     = 4;

   // Fixed-point formats
   localparam int TIME_W    = 16;
   localparam int AGE_W     = TIME_W + 1;
   localparam int ALPHA_W   = 13;
   localparam int FRAC_BITS = 12;
   localparam int PROD_W    = 2 * ALPHA_W;
   localparam logic [ALPHA_W-1:0] ONE_Q12 = ALPHA_W'(4096);

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // Queues and divider
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;
   localparam int DIV_STEPS   = FRAC_BITS;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_COUNT = 3'd0,
      CSR_KEYS_0_1  = 3'd1,
      CSR_KEYS_2_3  = 3'd2,
      CSR_KEYS_4_5  = 3'd3,
      CSR_KEYS_6_7  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [TIME_W-1:0]  life_total;
      logic [TIME_W-1:0]  life_remaining;
      logic [ALPHA_W-1:0] current_alpha;
   } req_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      logic [SEG_W-1:0]   segment_index;
   } rsp_type;

   // Classified request handed from the front end to the back end
   typedef struct packed {
      logic               interp;
      logic [ALPHA_W-1:0] alpha_fix;
      logic [SEG_W-1:0]   seg;
      logic [TIME_W-1:0]  num;
      logic [TIME_W-1:0]  den;
      logic [ALPHA_W-1:0] a0;
      logic [ALPHA_W-1:0] a1;
   } work_type;

   // Clamp a Q1.12 alpha to 1.0
   function automatic logic [ALPHA_W-1:0] sat_alpha(input logic [ALPHA_W-1:0] a);
      return (a > ONE_Q12) ? ONE_Q12 : a;
   endfunction

endpackage

// ===== design/keyframe_alpha_interpolator.sv =====
// Keyframe alpha interpolator: one particle request in, one alpha result out.
// Depends on kai_pkg, kai_front, kai_queue and kai_back.
//
// Takes one request per clock and returns one result per clock when the
// result side keeps popping. A request accepted at the request ports passes
// through the request queue, the fraction divider stages (one quotient bit
// per stage) and the blend multipliers, which write the result queue.
// Requests that need no interpolation travel the same path, so results stay
// in order. Keyframe registers are written through the csr port; the user
// must write them only while the block is idle, as the block itself does not enforce this.
module keyframe_alpha_interpolator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  kai_pkg::req_type                req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output kai_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_enable,
   input  logic [kai_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kai_pkg::CSR_DATA_W-1:0]  csr_data
);
   import kai_pkg::*;

   work_type front_work;
   work_type queue_head;
   logic     queue_empty;
   logic     queue_take;
   logic     req_accept;

   assign req_accept = req_push && !req_full;

   // Classify requests against the keyframe table
   kai_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_data         (req_data),
      .work             (front_work)
   );

   // Decouple front and back
   kai_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_work),
      .pop       (queue_take),
      .full      (req_full),
      .empty     (queue_empty),
      .head      (queue_head)
   );

   // Divide, blend and queue results
   kai_back u_back (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (!queue_empty),
      .issue_data  (queue_head),
      .issue_take  (queue_take),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_data    (rsp_data)
   );

   // Results never exceed one
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.alpha <= ONE_Q12))
      else $error("result alpha above one");

   // Segment index never exceeds the key count limit
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.segment_index <= SEG_W'(KEYS)))
      else $error("segment index out of range");

   // Reset leaves no results pending
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // Back end only takes from a non-empty queue
   assert property (@(posedge clock) disable iff (reset)
      queue_take |-> !queue_empty)
      else $error("request taken from empty queue");

endmodule

// ===== design/kai_front.sv =====
// Front end: holds the keyframe registers and classifies each request.
// Depends on kai_pkg.
module kai_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [kai_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kai_pkg::CSR_DATA_W-1:0]  csr_data,
   input  kai_pkg::req_type                req_data,
   output kai_pkg::work_type               work
);
   import kai_pkg::*;

   logic [SEG_W-1:0]      key_count_ff;
   logic [CSR_DATA_W-1:0] key_regs_ff [KEY_REGS];

   logic [TIME_W-1:0]     key_time  [KEYS];
   logic [ALPHA_W-1:0]    key_alpha [KEYS];
   logic [KEYS-1:0]       hit;
   logic [SEG_W-1:0]      n_keys;
   logic [SEG_W-1:0]      idx;
   logic [KEY_IDX_W-1:0]  cur_k;
   logic [KEY_IDX_W-1:0]  prev_k;
   logic [KEY_IDX_W-1:0]  last_k;
   logic signed [AGE_W-1:0] age;
   logic [AGE_W-1:0]      num_wide;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
         for (int r = 0; r < KEY_REGS; r++) begin
            key_regs_ff[r] <= '0;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_COUNT: key_count_ff   <= csr_data[SEG_W-1:0];
            CSR_KEYS_0_1:  key_regs_ff[0] <= csr_data;
            CSR_KEYS_2_3:  key_regs_ff[1] <= csr_data;
            CSR_KEYS_4_5:  key_regs_ff[2] <= csr_data;
            CSR_KEYS_6_7:  key_regs_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // Unpack keys: even key in the low half, odd key in the high half
   for (genvar k = 0; k < KEYS; k++) begin : g_key
      assign key_time[k]  = key_regs_ff[k >> 1][(k & 1) * 32 +: TIME_W];
      assign key_alpha[k] = sat_alpha(key_regs_ff[k >> 1][(k & 1) * 32 + 16 +: ALPHA_W]);
   end

   // Age and effective key count
   assign age    = $signed({1'b0, req_data.life_total}) - $signed({1'b0, req_data.life_remaining});
   assign n_keys = (key_count_ff > SEG_W'(KEYS)) ? SEG_W'(KEYS) : key_count_ff;

   // Compare age against all keys at once
   always_comb begin
      for (int k = 0; k < KEYS; k++) begin
         hit[k] = (SEG_W'(k) < n_keys) && (age <= $signed({1'b0, key_time[k]}));
      end
   end

   // Pick the first key at or above the age
   always_comb begin
      idx = n_keys;
      for (int k = KEYS - 1; k >= 0; k--) begin
         if (hit[k]) begin
            idx = SEG_W'(k);
         end
      end
   end

   assign cur_k    = idx[KEY_IDX_W-1:0];
   assign prev_k   = cur_k - KEY_IDX_W'(1);
   assign last_k   = KEY_IDX_W'(n_keys - SEG_W'(1));
   assign num_wide = AGE_W'(age - $signed({1'b0, key_time[prev_k]}));

   // Classify: pass-through, first key, last key or interpolation
   always_comb begin
      work           = '0;
      work.seg       = idx;
      work.num       = num_wide[TIME_W-1:0];
      work.den       = key_time[cur_k] - key_time[prev_k];
      work.a0        = key_alpha[prev_k];
      work.a1        = key_alpha[cur_k];
      if (n_keys == '0) begin
         work.alpha_fix = sat_alpha(req_data.current_alpha);
      end else if (n_keys == SEG_W'(1) || idx == '0) begin
         work.alpha_fix = key_alpha[0];
      end else if (idx == n_keys) begin
         work.alpha_fix = key_alpha[last_k];
      end else begin
         work.interp    = 1'b1;
      end
   end

endmodule

// ===== design/kai_queue.sv =====
// Short request queue between the front end and the back end.
// Depends on kai_pkg for the work_type payload.
module kai_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kai_pkg::work_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output kai_pkg::work_type head
);
   import kai_pkg::*;

   work_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;

   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   // Store incoming requests
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/kai_back.sv =====
// Back end: pipelined fraction divider, blend multiply and result queue.
// Depends on kai_pkg.
module kai_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              issue_valid,
   input  kai_pkg::work_type issue_data,
   output logic              issue_take,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output kai_pkg::rsp_type  rsp_data
);
   import kai_pkg::*;

   typedef struct packed {
      logic               interp;
      logic [ALPHA_W-1:0] alpha_fix;
      logic [SEG_W-1:0]   seg;
      logic [ALPHA_W-1:0] a0;
      logic [ALPHA_W-1:0] a1;
      logic [TIME_W-1:0]  den;
      logic [TIME_W-1:0]  rem;
      logic [ALPHA_W-1:0] quo;
   } div_type;

   typedef struct packed {
      logic               interp;
      logic [ALPHA_W-1:0] alpha_fix;
      logic [SEG_W-1:0]   seg;
      logic [PROD_W-1:0]  p1;
      logic [PROD_W-1:0]  p0;
   } mul_type;

   // One restoring-division step: shift, compare, subtract
   function automatic div_type div_step(input div_type d);
      div_type           r;
      logic [TIME_W:0]   r2;
      logic              ge;
      r2    = {d.rem, 1'b0};
      ge    = (r2 >= {1'b0, d.den});
      r     = d;
      r.rem = ge ? TIME_W'(r2 - {1'b0, d.den}) : r2[TIME_W-1:0];
      r.quo = {d.quo[ALPHA_W-2:0], ge};
      return r;
   endfunction

   div_type                div_ff   [DIV_STEPS+1];
   div_type                div_in   [DIV_STEPS+1];
   logic [DIV_STEPS:0]     div_valid_ff;
   mul_type                mul_ff;
   logic                   mul_valid_ff;
   logic                   advance;
   logic                   first_ge;

   rsp_type                out_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] out_wr_ff;
   logic [QUEUE_PTR_W-1:0] out_rd_ff;
   logic [QUEUE_CNT_W-1:0] out_count_ff;
   logic [QUEUE_CNT_W-1:0] out_count_in;
   logic                   out_full;
   logic                   out_write;
   logic                   out_read;
   logic [PROD_W:0]        blend_sum;
   logic [PROD_W-FRAC_BITS:0] blend_wide;
   logic [ALPHA_W-1:0]     blend_alpha;
   rsp_type                out_item;

   // Stall the whole pipe only when a finished result has nowhere to go
   assign out_full   = (out_count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign advance    = !(mul_valid_ff && out_full);
   assign issue_take = issue_valid && advance;

   // First quotient bit, then one bit per stage
   assign first_ge = (issue_data.num >= issue_data.den);

   always_comb begin
      div_in[0].interp    = issue_data.interp;
      div_in[0].alpha_fix = issue_data.alpha_fix;
      div_in[0].seg       = issue_data.seg;
      div_in[0].a0        = issue_data.a0;
      div_in[0].a1        = issue_data.a1;
      div_in[0].den       = issue_data.den;
      div_in[0].rem       = first_ge ? (issue_data.num - issue_data.den) : issue_data.num;
      div_in[0].quo       = {{(ALPHA_W-1){1'b0}}, first_ge};
      for (int s = 1; s <= DIV_STEPS; s++) begin
         div_in[s] = div_step(div_ff[s-1]);
      end
   end

   // Advance divider and multiply stages
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s <= DIV_STEPS; s++) begin
            div_ff[s] <= div_in[s];
         end
         mul_ff.interp    <= div_ff[DIV_STEPS].interp;
         mul_ff.alpha_fix <= div_ff[DIV_STEPS].alpha_fix;
         mul_ff.seg       <= div_ff[DIV_STEPS].seg;
         mul_ff.p1        <= PROD_W'(div_ff[DIV_STEPS].a1) * PROD_W'(div_ff[DIV_STEPS].quo);
         mul_ff.p0        <= PROD_W'(div_ff[DIV_STEPS].a0)
                           * PROD_W'(ONE_Q12 - div_ff[DIV_STEPS].quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= '0;
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         div_valid_ff <= {div_valid_ff[DIV_STEPS-1:0], issue_valid};
         mul_valid_ff <= div_valid_ff[DIV_STEPS];
      end
   end

   // Blend the two key alphas, truncate and clamp to one
   assign blend_sum   = {1'b0, mul_ff.p1} + {1'b0, mul_ff.p0};
   assign blend_wide  = blend_sum[PROD_W:FRAC_BITS];
   assign blend_alpha = (blend_wide > (PROD_W-FRAC_BITS+1)'(ONE_Q12)) ? ONE_Q12
                                                                      : blend_wide[ALPHA_W-1:0];

   always_comb begin
      out_item.alpha         = mul_ff.interp ? blend_alpha : mul_ff.alpha_fix;
      out_item.segment_index = mul_ff.seg;
   end

   // Result queue
   assign out_write = mul_valid_ff && advance;
   assign out_read  = rsp_pop && !rsp_empty;
   assign rsp_empty = (out_count_ff == '0);
   assign rsp_data  = out_mem_ff[out_rd_ff];

   always_comb begin
      out_count_in = out_count_ff;
      if (out_write && !out_read) begin
         out_count_in = out_count_ff + QUEUE_CNT_W'(1);
      end else if (out_read && !out_write) begin
         out_count_in = out_count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (out_write) begin
         out_mem_ff[out_wr_ff] <= out_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         if (out_write) begin
            out_wr_ff <= out_wr_ff + QUEUE_PTR_W'(1);
         end
         if (out_read) begin
            out_rd_ff <= out_rd_ff + QUEUE_PTR_W'(1);
         end
         out_count_ff <= out_count_in;
      end
   end

endmodule
